// ----- design/aptw_pkg.sv -----
// aptw_pkg: shared types and constants of the ancestor path walker.
// No dependencies; imported by the core and the checker.
package aptw_pkg;

   localparam int DevIdW   = 16;
   localparam int PosW     = 4;
   localparam int PathLenW = 5;

   typedef logic [DevIdW-1:0] dev_id_type;

   localparam dev_id_type NoParent  = 16'hFFFF;
   localparam logic       KindLoad  = 1'b0;
   localparam logic       KindQuery = 1'b1;

endpackage

// ----- design/aptw_ram.sv -----
// aptw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module aptw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ancestor_path_walker_core.sv -----
// ancestor_path_walker_core: record table, upward walk sequencer and path emitter.
// Depends on aptw_pkg and aptw_ram (record table and path store).
// Load: busy stays low. Query: takes the target, then per level scans the records,
// one compare a cycle, then emits the path, one result a cycle.
// The receiver cannot stall results. Synchronous reset empties the table at once.
module ancestor_path_walker_core
   import aptw_pkg::*;
#(
   parameter int MAX_DEVICES = 16,
   parameter int MAX_PATH    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [DevIdW-1:0]   req_device_id,
   input  logic [DevIdW-1:0]   req_parent_id,
   output logic                rsp_valid,
   output logic [DevIdW-1:0]   rsp_path_id,
   output logic [PosW-1:0]     rsp_position,
   output logic [PathLenW-1:0] rsp_path_length,
   output logic                rsp_last
);

   localparam int CntW   = $clog2(MAX_DEVICES + 1);
   localparam int RecAw  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int LenW   = $clog2(MAX_PATH + 1);
   localparam int PathAw = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [CntW-1:0]       count_ff;
   dev_id_type            cur_ff;
   logic [LenW-1:0]       len_ff;
   logic [CntW-1:0]       scan_ff;
   logic                  cmp_ff;
   logic [LenW-1:0]       emit_k_ff;
   logic                  rsp_valid_ff;
   logic [PosW-1:0]       rsp_position_ff;
   logic [PathLenW-1:0]   rsp_path_length_ff;
   logic                  rsp_last_ff;

   logic                  accept;
   logic                  rec_wr_en;
   logic                  rec_rd_en;
   logic [2*DevIdW-1:0]   rec_rd_data;
   logic                  hit;
   dev_id_type            up_id;
   logic                  path_wr_en;
   logic [PathAw-1:0]     path_wr_addr;
   dev_id_type            path_wr_data;
   logic                  emit_issue;
   logic [LenW-1:0]       emit_addr;
   logic [LenW-1:0]       len_in;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   assign rec_wr_en = accept && (req_kind == KindLoad) && (count_ff < CntW'(MAX_DEVICES));
   assign hit       = cmp_ff && (rec_rd_data[2*DevIdW-1:DevIdW] == cur_ff);
   assign up_id     = rec_rd_data[DevIdW-1:0];
   assign rec_rd_en = (state_ff == ST_SCAN) && !hit && (scan_ff < count_ff);
   assign len_in    = len_ff + LenW'(1);

   assign path_wr_en   = (accept && (req_kind == KindQuery)) ||
                         ((state_ff == ST_SCAN) && hit && (up_id != NoParent));
   assign path_wr_addr = (state_ff == ST_IDLE) ? '0 : len_ff[PathAw-1:0];
   assign path_wr_data = (state_ff == ST_IDLE) ? req_device_id : up_id;

   assign emit_issue = (state_ff == ST_EMIT) && (emit_k_ff < len_ff);
   assign emit_addr  = len_ff - LenW'(1) - emit_k_ff;

   aptw_ram #(
      .WIDTH (2 * DevIdW),
      .DEPTH (MAX_DEVICES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (count_ff[RecAw-1:0]),
      .wr_data ({req_device_id, req_parent_id}),
      .rd_en   (rec_rd_en),
      .rd_addr (scan_ff[RecAw-1:0]),
      .rd_data (rec_rd_data)
   );

   aptw_ram #(
      .WIDTH (DevIdW),
      .DEPTH (MAX_PATH)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (path_wr_en),
      .wr_addr (path_wr_addr),
      .wr_data (path_wr_data),
      .rd_en   (emit_issue),
      .rd_addr (emit_addr[PathAw-1:0]),
      .rd_data (rsp_path_id)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (rec_wr_en) begin
                  count_ff <= count_ff + CntW'(1);
               end
               if (accept && (req_kind == KindQuery)) begin
                  cur_ff    <= req_device_id;
                  len_ff    <= LenW'(1);
                  scan_ff   <= '0;
                  cmp_ff    <= 1'b0;
                  emit_k_ff <= '0;
                  state_ff  <= (LenW'(1) == LenW'(MAX_PATH)) ? ST_EMIT : ST_SCAN;
               end
            end
            ST_SCAN: begin
               priority if (hit) begin
                  cmp_ff  <= 1'b0;
                  scan_ff <= '0;
                  if (up_id == NoParent) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     cur_ff <= up_id;
                     len_ff <= len_in;
                     if (len_in == LenW'(MAX_PATH)) begin
                        state_ff <= ST_EMIT;
                     end
                  end
               end else if (rec_rd_en) begin
                  scan_ff <= scan_ff + CntW'(1);
                  cmp_ff  <= 1'b1;
               end else begin
                  cmp_ff   <= 1'b0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_issue) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_position_ff    <= PosW'(emit_k_ff);
                  rsp_path_length_ff <= PathLenW'(len_ff);
                  rsp_last_ff        <= (emit_k_ff == len_ff - LenW'(1));
                  emit_k_ff          <= emit_k_ff + LenW'(1);
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_path_length = rsp_path_length_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- design/aptw_checker.sv -----
// aptw_checker: port-level checks of the ancestor path walker result sequence.
// Depends on aptw_pkg; bound to ancestor_path_walker_core below.
module aptw_checker
   import aptw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_kind,
   input logic                rsp_valid,
   input logic [PosW-1:0]     rsp_position,
   input logic [PathLenW-1:0] rsp_path_length,
   input logic                rsp_last
);

   // load transfer never holds the block
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KindLoad) |=> !busy)
      else $error("busy after load transfer");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result after last");

   a_path_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid &&
         (rsp_position == $past(rsp_position) + PosW'(1)) && $stable(rsp_path_length))
      else $error("path results not contiguous");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_position == PosW'(rsp_path_length - PathLenW'(1)))
      else $error("last mark at wrong position");

   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

endmodule

bind ancestor_path_walker_core aptw_checker u_aptw_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_position    (rsp_position),
   .rsp_path_length (rsp_path_length),
   .rsp_last        (rsp_last)
);
